// ===== hw/rtl/psgeg_pkg.sv =====
`timescale 1ns / 1ps

package psgeg_pkg;

  // Level steps of the envelope (legal range 16 .. 32)
  localparam int STEPS_DEF = 32;

  localparam int LEVEL_W    = 5;
  localparam int PERIOD_W   = 16;
  localparam int PRESCALE_W = 20;
  localparam int SHAPE_W    = 4;

  // Shape bit positions
  localparam int SHAPE_CONT_BIT   = 3;
  localparam int SHAPE_ATTACK_BIT = 2;
  localparam int SHAPE_ALT_BIT    = 1;
  localparam int SHAPE_HOLD_BIT   = 0;

  // Request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_SHAPE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [SHAPE_W-1:0] shape_code;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               holding;
    logic               rising;
  } out_word_t;

endpackage

// ===== hw/rtl/psg_envelope_generator.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Word
// in_     | input     | in_valid / in_ready   | psgeg_pkg::in_word_t (tick or shape write)
// out_    | output    | out_valid / out_ready | psgeg_pkg::out_word_t (level, holding, rising)
// cfg_    | input     | cfg_valid / cfg_ready | env_period, 16 bits
//
// One word per cycle while the output is not stalled; each input word yields its result in the cycle after acceptance.
// Prescaler compare and step update are combinational and feed the result register directly.
// rst_n is synchronous: level 0, counting up, not held, shape 0, prescaler 0, period 0.
// in_ready is high while the result register is empty or being drained; a stalled output holds it low.
// cfg_ready is always high.

module psg_envelope_generator #(
  parameter int STEPS = psgeg_pkg::STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  psgeg_pkg::in_word_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psgeg_pkg::out_word_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psgeg_pkg::PERIOD_W-1:0]      cfg_env_period
);

  localparam logic [psgeg_pkg::LEVEL_W-1:0] LEVEL_TOP = psgeg_pkg::LEVEL_W'(STEPS - 1);
  localparam logic [psgeg_pkg::LEVEL_W-1:0] LEVEL_BOT = '0;

  logic [psgeg_pkg::PERIOD_W-1:0]   period_r;
  logic [psgeg_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic                             up_r, up_nxt;
  logic                             held_r, held_nxt;
  logic [psgeg_pkg::SHAPE_W-1:0]    shape_r, shape_nxt;
  logic [psgeg_pkg::PRESCALE_W-1:0] presc_r, presc_nxt;
  logic                             out_valid_r;
  psgeg_pkg::out_word_t             out_data_r, out_data_nxt;

  logic                             in_fire;
  logic [psgeg_pkg::PERIOD_W-1:0]   per_eff;
  logic [psgeg_pkg::PRESCALE_W-1:0] limit;
  logic [psgeg_pkg::PRESCALE_W-1:0] presc_inc;
  logic                             at_end;
  logic                             atk, alt, cont, hold, new_atk;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Prescaler limit: 8 * max(1, period)
  assign per_eff   = (period_r == '0) ? psgeg_pkg::PERIOD_W'(1) : period_r;
  assign limit     = {1'b0, per_eff, 3'b000};
  assign presc_inc = presc_r + psgeg_pkg::PRESCALE_W'(1);

  assign atk     = shape_r[psgeg_pkg::SHAPE_ATTACK_BIT];
  assign alt     = shape_r[psgeg_pkg::SHAPE_ALT_BIT];
  assign cont    = shape_r[psgeg_pkg::SHAPE_CONT_BIT];
  assign hold    = shape_r[psgeg_pkg::SHAPE_HOLD_BIT];
  assign new_atk = in_data.shape_code[psgeg_pkg::SHAPE_ATTACK_BIT];
  assign at_end  = up_r ? (level_r >= LEVEL_TOP) : (level_r == LEVEL_BOT);

  // Envelope state update for one accepted word
  always_comb begin
    level_nxt = level_r;
    up_nxt    = up_r;
    held_nxt  = held_r;
    shape_nxt = shape_r;
    presc_nxt = presc_r;
    if (in_data.req_type == psgeg_pkg::REQ_SHAPE) begin
      // shape write restarts the sweep
      shape_nxt = in_data.shape_code;
      up_nxt    = new_atk;
      level_nxt = new_atk ? LEVEL_BOT : LEVEL_TOP;
      held_nxt  = 1'b0;
      presc_nxt = '0;
    end else begin
      presc_nxt = presc_inc;
      if (presc_inc >= limit) begin
        presc_nxt = '0;
        if (!held_r) begin
          if (!at_end) begin
            level_nxt = up_r ? level_r + psgeg_pkg::LEVEL_W'(1)
                             : level_r - psgeg_pkg::LEVEL_W'(1);
          end else if (!cont) begin
            // one sweep only: drop to zero and stay
            level_nxt = LEVEL_BOT;
            held_nxt  = 1'b1;
          end else if (hold) begin
            if (alt) begin
              level_nxt = atk ? LEVEL_BOT : LEVEL_TOP;
            end else begin
              level_nxt = up_r ? LEVEL_TOP : LEVEL_BOT;
            end
            held_nxt = 1'b1;
          end else begin
            // wrap, reversing first when alternating
            up_nxt    = alt ? !up_r : up_r;
            level_nxt = (alt ? !up_r : up_r) ? LEVEL_BOT : LEVEL_TOP;
          end
        end
      end
    end
    out_data_nxt.level   = level_nxt;
    out_data_nxt.holding = held_nxt;
    out_data_nxt.rising  = up_nxt;
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= '0;
      level_r     <= '0;
      up_r        <= 1'b1;
      held_r      <= 1'b0;
      shape_r     <= '0;
      presc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_env_period;
      end
      if (in_fire) begin
        level_r     <= level_nxt;
        up_r        <= up_nxt;
        held_r      <= held_nxt;
        shape_r     <= shape_nxt;
        presc_r     <= presc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word, loaded on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (level_r == LEVEL_BOT || level_r == LEVEL_TOP))
    else $error("held envelope not at an end level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_TOP)
    else $error("envelope level beyond top step");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && out_data_r.level == level_r &&
                 out_data_r.holding == held_r && out_data_r.rising == up_r))
    else $error("result word does not match envelope state");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == psgeg_pkg::REQ_SHAPE) |=>
      (!held_r && presc_r == '0 && up_r == $past(new_atk)))
    else $error("shape write did not restart the envelope");

  a_presc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == psgeg_pkg::REQ_TICK) |=> presc_r < $past(limit))
    else $error("prescaler left above its limit after a tick");
`endif

endmodule

// ===== tb/envelope_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the envelope generator, keeps its own copy of
// the envelope state, and checks every result word against the prediction.
module envelope_checker #(
  parameter int STEPS = psgeg_pkg::STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  psgeg_pkg::in_word_t            in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  psgeg_pkg::out_word_t           out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [psgeg_pkg::PERIOD_W-1:0] cfg_env_period,
  output int                             outstanding,
  output int                             fail_count
);

  localparam logic [psgeg_pkg::LEVEL_W-1:0] TOP_LEVEL = psgeg_pkg::LEVEL_W'(STEPS - 1);

  // predicted envelope state
  logic [psgeg_pkg::PERIOD_W-1:0]   period;
  logic [psgeg_pkg::LEVEL_W-1:0]    lvl;
  logic                             going_up;
  logic                             frozen;
  logic [psgeg_pkg::SHAPE_W-1:0]    shape;
  logic [psgeg_pkg::PRESCALE_W-1:0] prescale;

  psgeg_pkg::out_word_t envelope_due[$];
  psgeg_pkg::out_word_t fresh;
  psgeg_pkg::out_word_t due;
  psgeg_pkg::out_word_t got;
  int                   fails;

  // one level step, with the end-of-sweep rules of the shape
  function automatic void step_envelope();
    logic at_end;
    if (!frozen) begin
      at_end = going_up ? (lvl >= TOP_LEVEL) : (lvl == '0);
      if (!at_end) begin
        lvl = going_up ? lvl + psgeg_pkg::LEVEL_W'(1) : lvl - psgeg_pkg::LEVEL_W'(1);
      end else if (!shape[psgeg_pkg::SHAPE_CONT_BIT]) begin
        // single sweep: drop to zero and stay there
        lvl    = '0;
        frozen = 1'b1;
      end else if (shape[psgeg_pkg::SHAPE_HOLD_BIT]) begin
        if (shape[psgeg_pkg::SHAPE_ALT_BIT]) begin
          lvl = shape[psgeg_pkg::SHAPE_ATTACK_BIT] ? '0 : TOP_LEVEL;
        end else begin
          lvl = going_up ? TOP_LEVEL : '0;
        end
        frozen = 1'b1;
      end else begin
        // repeat: reverse first when alternating
        if (shape[psgeg_pkg::SHAPE_ALT_BIT]) going_up = !going_up;
        lvl = going_up ? '0 : TOP_LEVEL;
      end
    end
  endfunction

  // apply one input word and return the level word it should produce
  function automatic psgeg_pkg::out_word_t envelope_advance(input psgeg_pkg::in_word_t w);
    psgeg_pkg::out_word_t r;
    int                   limit;
    if (w.req_type == psgeg_pkg::REQ_SHAPE) begin
      shape    = w.shape_code;
      going_up = w.shape_code[psgeg_pkg::SHAPE_ATTACK_BIT];
      lvl      = going_up ? '0 : TOP_LEVEL;
      frozen   = 1'b0;
      prescale = '0;
    end else begin
      limit    = ((period == '0) ? 1 : int'(period)) * 8;
      prescale = prescale + psgeg_pkg::PRESCALE_W'(1);
      if (int'(prescale) >= limit) begin
        prescale = '0;
        step_envelope();
      end
    end
    r.level   = lvl;
    r.holding = frozen;
    r.rising  = going_up;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      period   = '0;
      lvl      = '0;
      going_up = 1'b1;
      frozen   = 1'b0;
      shape    = '0;
      prescale = '0;
      fails    = 0;
      envelope_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) period = cfg_env_period;
      if (in_valid && in_ready) begin
        fresh        = envelope_advance(in_data);
        envelope_due = {envelope_due, fresh};
      end

      // compare the result word with the oldest prediction
      if (out_valid && out_ready) begin
        got = out_data;
        if (envelope_due.size() == 0) begin
          $display("%0t: result word with none expected: got level %0d holding %0d rising %0d",
                   $time, got.level, got.holding, got.rising);
          fails++;
        end else begin
          due = envelope_due.pop_front();
          if (got.level !== due.level) begin
            $display("%0t: level mismatch: expected %0d, got %0d", $time, due.level, got.level);
            fails++;
          end
          if (got.holding !== due.holding) begin
            $display("%0t: holding mismatch: expected %0d, got %0d",
                     $time, due.holding, got.holding);
            fails++;
          end
          if (got.rising !== due.rising) begin
            $display("%0t: rising mismatch: expected %0d, got %0d",
                     $time, due.rising, got.rising);
            fails++;
          end
        end
      end
    end
    outstanding <= envelope_due.size();
    fail_count  <= fails;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  psgeg_pkg::in_word_t            in_data;
  logic                           out_valid;
  logic                           out_ready;
  psgeg_pkg::out_word_t           out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [psgeg_pkg::PERIOD_W-1:0] cfg_env_period;
  int                             outstanding;
  int                             fail_count;

  // no idling on either side while set
  logic                quiet;
  int                  words_sent;
  logic [15:0]         swept;

  psg_envelope_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_env_period(cfg_env_period)
  );

  envelope_checker env_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_env_period(cfg_env_period),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // send one input word after a random gap (none while quiet); returns on the accepting edge
  task automatic send_word(input logic req, input logic [psgeg_pkg::SHAPE_W-1:0] code);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.req_type   <= req;
    in_data.shape_code <= code;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(psgeg_pkg::REQ_TICK, psgeg_pkg::SHAPE_W'($urandom_range(0, 15)));
  endtask

  // wait for all results, then let the pipeline settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // period register is only written while the block is idle
  task automatic write_period(input logic [psgeg_pkg::PERIOD_W-1:0] p);
    wait_idle();
    cfg_valid      <= 1'b1;
    cfg_env_period <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall before each word (none while quiet)
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    logic                           is_long;
    logic [psgeg_pkg::SHAPE_W-1:0]  code;
    logic [psgeg_pkg::PERIOD_W-1:0] per;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    cfg_valid      <= 1'b0;
    cfg_env_period <= '0;
    quiet          = 1'b0;
    words_sent     = 0;
    swept          = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ticks from reset, shape extremes, attack and continue bits alone, attack with hold
    send_word(psgeg_pkg::REQ_TICK, 4'hF);
    send_word(psgeg_pkg::REQ_TICK, 4'h0);
    send_word(psgeg_pkg::REQ_SHAPE, 4'hF);
    send_word(psgeg_pkg::REQ_TICK, 4'h0);
    send_word(psgeg_pkg::REQ_SHAPE, 4'h0);
    send_word(psgeg_pkg::REQ_TICK, 4'hF);
    send_word(psgeg_pkg::REQ_SHAPE, psgeg_pkg::SHAPE_W'(1 << psgeg_pkg::SHAPE_ATTACK_BIT));
    send_word(psgeg_pkg::REQ_TICK, 4'h0);
    send_word(psgeg_pkg::REQ_SHAPE, psgeg_pkg::SHAPE_W'(1 << psgeg_pkg::SHAPE_CONT_BIT));
    send_word(psgeg_pkg::REQ_SHAPE,
              psgeg_pkg::SHAPE_W'((1 << psgeg_pkg::SHAPE_ATTACK_BIT) |
                                  (1 << psgeg_pkg::SHAPE_HOLD_BIT)));

    // largest period, then lowered below the running prescaler: next tick steps
    write_period('1);
    send_word(psgeg_pkg::REQ_SHAPE,
              psgeg_pkg::SHAPE_W'((1 << psgeg_pkg::SHAPE_CONT_BIT) |
                                  (1 << psgeg_pkg::SHAPE_ATTACK_BIT)));
    send_ticks(12);
    write_period(16'd1);
    send_ticks(2);

    // random phases; long ones sweep past an end at the shortest period, each with a
    // shape not yet swept while any remains, and only before 300 words have been sent
    while (words_sent < 700) begin
      quiet   = ($urandom_range(0, 3) == 0);
      is_long = (words_sent < 300) && (swept == '0 || $urandom_range(0, 1) == 1);
      if (is_long) begin
        write_period(psgeg_pkg::PERIOD_W'($urandom_range(0, 1)));
        code = psgeg_pkg::SHAPE_W'($urandom_range(0, 15));
        while (swept != '1 && swept[code]) code = code + psgeg_pkg::SHAPE_W'(1);
        swept[code] = 1'b1;
        send_word(psgeg_pkg::REQ_SHAPE, code);
        send_ticks($urandom_range(257, 400));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0:       per = '0;
            1:       per = '1;
            2:       per = psgeg_pkg::PERIOD_W'($urandom_range(2, 4));
            3:       per = psgeg_pkg::PERIOD_W'($urandom);
            default: per = 16'd1;
          endcase
          write_period(per);
        end
        // sometimes keep the running envelope across the phase
        if ($urandom_range(0, 3) != 0) begin
          send_word(psgeg_pkg::REQ_SHAPE, psgeg_pkg::SHAPE_W'($urandom_range(0, 15)));
        end
        send_ticks($urandom_range(1, 40));
      end
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
